[rtl/core/bfir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfir_pkg: shared types and constants of the banked FIR filter
// Field widths, function codes, controller states and command bundle.
// ----------------------------------------------------------------------------
package bfir_pkg;

	// field widths fixed by the item format
	localparam int FUNC_W   = 1;
	localparam int BANK_W   = 2;
	localparam int TAPIDX_W = 5;
	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 16;
	localparam int SEL_W    = 2;
	localparam int PROD_W   = SAMPLE_W + COEFF_W;

	// function codes of an input item
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FILTER = 1'b1;

	// result scaling: Q1.15 coefficients
	localparam int FRAC_BITS = 15;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ACC,
		ST_FINISH
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_we;  // write one coefficient
		logic start;    // shift sample in, clear accumulator
		logic issue;    // read one tap and rotate delay line
		logic finish;   // load the output register
	} cmd_t;

endpackage

[rtl/core/bfir_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfir_if: valid/ready channels of the banked FIR filter
// Input item channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------

// input item channel
interface bfir_in_if;
	logic                               valid;
	logic                               ready;
	logic [bfir_pkg::FUNC_W-1:0]        func;
	logic [bfir_pkg::BANK_W-1:0]        bank_index;
	logic [bfir_pkg::TAPIDX_W-1:0]      tap_index;
	logic signed [bfir_pkg::COEFF_W-1:0]  coeff_value;
	logic signed [bfir_pkg::SAMPLE_W-1:0] audio_in;

	modport source (
		output valid, func, bank_index, tap_index, coeff_value, audio_in,
		input  ready
	);
	modport sink (
		input  valid, func, bank_index, tap_index, coeff_value, audio_in,
		output ready
	);
endinterface

// result channel
interface bfir_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [bfir_pkg::SAMPLE_W-1:0] audio_out;

	modport source (
		output valid, audio_out,
		input  ready
	);
	modport sink (
		input  valid, audio_out,
		output ready
	);
endinterface

[rtl/core/bfir_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfir_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/bfir_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfir_ctrl: sequencer of the banked FIR filter
// Accepts items, steps the tap counter, drains the MAC pipe, hands off results.
// ----------------------------------------------------------------------------
module bfir_ctrl #(
	parameter int TAPS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [bfir_pkg::FUNC_W-1:0] in_func,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bfir_pkg::cmd_t              cmd,
	output logic [$clog2(TAPS)-1:0]     mac_tap
);

	localparam int TW = $clog2(TAPS);
	localparam logic [TW-1:0] LAST_TAP = TW'(TAPS - 1);

	bfir_pkg::state_t state_q, state_d;
	logic [TW-1:0]    tap_q;
	logic             out_valid_q;
	logic             last_tap;

	assign last_tap  = (tap_q == LAST_TAP);
	assign mac_tap   = tap_q;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfir_pkg::ST_IDLE: begin
				if (in_valid && in_func == bfir_pkg::FUNC_FILTER) begin
					state_d = bfir_pkg::ST_MAC;
				end
			end
			bfir_pkg::ST_MAC: begin
				if (last_tap) begin
					state_d = bfir_pkg::ST_DRAIN;
				end
			end
			bfir_pkg::ST_DRAIN:  state_d = bfir_pkg::ST_ACC;
			bfir_pkg::ST_ACC:    state_d = bfir_pkg::ST_FINISH;
			bfir_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = bfir_pkg::ST_IDLE;
				end
			end
			default: state_d = bfir_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			bfir_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_we = in_valid && in_func == bfir_pkg::FUNC_LOAD;
				cmd.start   = in_valid && in_func == bfir_pkg::FUNC_FILTER;
			end
			bfir_pkg::ST_MAC: begin
				cmd.issue = 1'b1;
			end
			bfir_pkg::ST_FINISH: begin
				cmd.finish = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state, tap counter and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfir_pkg::ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bfir_pkg::ST_MAC) begin
				tap_q <= last_tap ? '0 : tap_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// a result never overwrites one still waiting
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// an accepted sample starts the tap sweep
	a_filter_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_func == bfir_pkg::FUNC_FILTER)
		|=> (state_q == bfir_pkg::ST_MAC && tap_q == '0))
		else $error("tap sweep did not start at tap zero");

	// the sweep covers every tap
	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfir_pkg::ST_MAC && !last_tap) |=> state_q == bfir_pkg::ST_MAC)
		else $error("tap sweep left early");

	// a coefficient load leaves the controller idle and produces no result
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_we |=> (state_q == bfir_pkg::ST_IDLE && !cmd.finish))
		else $error("load transaction left idle");
`endif

endmodule

[rtl/core/bfir_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfir_datapath: delay line, coefficient RAM and shared MAC
// Rotating delay line, registered multiply, wide accumulate, truncate and clip.
// ----------------------------------------------------------------------------
module bfir_datapath #(
	parameter int TAPS      = 32,
	parameter int NUM_BANKS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bfir_pkg::SEL_W-1:0]           cfg_wdata,
	input  logic [bfir_pkg::BANK_W-1:0]          bank_index,
	input  logic [bfir_pkg::TAPIDX_W-1:0]        tap_index,
	input  logic signed [bfir_pkg::COEFF_W-1:0]  coeff_value,
	input  logic signed [bfir_pkg::SAMPLE_W-1:0] audio_in,
	input  bfir_pkg::cmd_t                       cmd,
	input  logic [$clog2(TAPS)-1:0]              mac_tap,
	output logic signed [bfir_pkg::SAMPLE_W-1:0] audio_out
);

	localparam int DEPTH = NUM_BANKS * TAPS;
	localparam int AW    = $clog2(DEPTH);
	localparam int ACC_W = bfir_pkg::PROD_W + $clog2(TAPS);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 1;
	localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << bfir_pkg::FRAC_BITS) - 1);

	logic [bfir_pkg::SEL_W-1:0]           sel_q;
	logic [bfir_pkg::SEL_W-1:0]           sel_clamped;
	logic signed [bfir_pkg::SAMPLE_W-1:0] line_q [TAPS];
	logic signed [bfir_pkg::SAMPLE_W-1:0] samp_s1;
	logic                                 v_s1;
	logic signed [bfir_pkg::PROD_W-1:0]   prod_s2;
	logic                                 v_s2;
	logic signed [ACC_W-1:0]              acc_q;
	logic signed [bfir_pkg::SAMPLE_W-1:0] out_q;
	logic                                 ram_we;
	logic [AW-1:0]                        waddr;
	logic [AW-1:0]                        raddr;
	logic [bfir_pkg::COEFF_W-1:0]         rdata;
	logic signed [ACC_W-1:0]              biased;
	logic signed [ACC_W-1:0]              scaled;
	logic signed [bfir_pkg::SAMPLE_W-1:0] clipped;

	// bank select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (cfg_we) begin
			sel_q <= cfg_wdata;
		end
	end

	// out-of-range select uses the last bank
	assign sel_clamped = (32'(sel_q) >= NUM_BANKS) ? bfir_pkg::SEL_W'(NUM_BANKS - 1) : sel_q;

	// coefficient write: out-of-range loads are dropped
	assign ram_we = cmd.load_we && (32'(bank_index) < NUM_BANKS) && (32'(tap_index) < TAPS);
	assign waddr  = AW'(32'(bank_index) * TAPS + 32'(tap_index));
	assign raddr  = AW'(32'(sel_clamped) * TAPS + 32'(mac_tap));

	bfir_ram #(
		.WIDTH (bfir_pkg::COEFF_W),
		.DEPTH (DEPTH)
	) u_coeff_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (coeff_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// delay line: shift on a new sample, rotate once per tap during the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				line_q[i] <= '0;
			end
		end else if (cmd.start) begin
			line_q[0] <= audio_in;
			for (int i = 1; i < TAPS; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end else if (cmd.issue) begin
			line_q[TAPS-1] <= line_q[0];
			for (int i = 0; i < TAPS - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
		end
	end

	// MAC pipe valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// sample aligned with RAM read, then product
	always_ff @(posedge clk) begin
		samp_s1 <= line_q[0];
		prod_s2 <= $signed(rdata) * samp_s1;
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// scale toward zero and clip to 16 bits
	always_comb begin
		biased = acc_q + (acc_q[ACC_W-1] ? TRUNC_BIAS : '0);
		scaled = biased >>> bfir_pkg::FRAC_BITS;
		if (scaled > SAT_MAX) begin
			clipped = SAT_MAX[bfir_pkg::SAMPLE_W-1:0];
		end else if (scaled < SAT_MIN) begin
			clipped = SAT_MIN[bfir_pkg::SAMPLE_W-1:0];
		end else begin
			clipped = scaled[bfir_pkg::SAMPLE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= clipped;
		end
	end

	assign audio_out = out_q;

endmodule

[rtl/core/banked_fir_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_fir_filter: direct-form FIR filter with selectable coefficient banks
// Load transactions write Q1.15 taps; sample transactions produce one result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  item      in   valid / ready    func, bank_index, tap_index, coeff_value,
//                                  audio_in
//  result    out  valid / ready    audio_out
//  cfg       in   cfg_we           cfg_wdata (filter_select)
//
//  A load transaction writes its coefficient when accepted. A sample transaction
//  steps through MAC, DRAIN, ACC and FINISH: one shared MAC reads one coefficient
//  RAM word per cycle, then two pipe stages and a scale/clip step follow.
//  Reset clears the delay line, bank select and all control; the coefficient
//  RAM holds garbage until loaded.
//  A pending result does not block accepting the next transaction; a finished
//  sample waits in its last cycle until the result register is free.
// ----------------------------------------------------------------------------
module banked_fir_filter #(
	parameter int TAPS      = 32,
	parameter int NUM_BANKS = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bfir_in_if.sink                    item,
	bfir_out_if.source                 result,
	input  logic                       cfg_we,
	input  logic [bfir_pkg::SEL_W-1:0] cfg_wdata
);

	bfir_pkg::cmd_t          cmd;
	logic [$clog2(TAPS)-1:0] mac_tap;
	logic                    in_ready;
	logic                    out_valid;

	assign item.ready   = in_ready;
	assign result.valid = out_valid;

	bfir_ctrl #(
		.TAPS (TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_func   (item.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.mac_tap   (mac_tap)
	);

	bfir_datapath #(
		.TAPS      (TAPS),
		.NUM_BANKS (NUM_BANKS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.bank_index  (item.bank_index),
		.tap_index   (item.tap_index),
		.coeff_value (item.coeff_value),
		.audio_in    (item.audio_in),
		.cmd         (cmd),
		.mac_tap     (mac_tap),
		.audio_out   (result.audio_out)
	);

endmodule

[sim/banked_fir_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_fir_filter_test: self-checking testbench of the banked FIR filter
// Loads all coefficient banks and runs a short directed table with hand-typed
// results: zero output, full scale, both saturation limits and truncation
// toward zero. It then runs random phases of loads and samples under several
// bank selects and idle patterns, including one long result hold-off. Results
// without a typed value are compared with a software copy of the filter.
// ----------------------------------------------------------------------------
module banked_fir_filter_test;

	localparam int TAPS        = 32;
	localparam int NUM_BANKS   = 3;
	localparam int CYCLE_LIMIT = 600_000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 117;
	localparam int NUM_PHASES  = 8;

	typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [bfir_pkg::FUNC_W-1:0]          func;
		logic [bfir_pkg::BANK_W-1:0]          bank;
		logic [bfir_pkg::TAPIDX_W-1:0]        tap;
		logic signed [bfir_pkg::COEFF_W-1:0]  coeff;
		logic signed [bfir_pkg::SAMPLE_W-1:0] audio;
	} fir_item_t;

	typedef struct {
		fir_item_t                            it;
		bit                                   has_typed;
		logic signed [bfir_pkg::SAMPLE_W-1:0] typed_out;
	} table_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [bfir_pkg::SEL_W-1:0] cfg_wdata;

	bfir_in_if  item_ch ();
	bfir_out_if res_ch ();

	// filter state as seen from outside
	logic signed [bfir_pkg::SAMPLE_W-1:0] sample_hist [TAPS];
	logic signed [bfir_pkg::COEFF_W-1:0]  coeff_bank [NUM_BANKS][TAPS];
	logic [bfir_pkg::SEL_W-1:0]           bank_sel;

	logic signed [bfir_pkg::SAMPLE_W-1:0] expected_audio [$];
	table_row_t                           stim_table [$];

	int  err_count = 0;
	int  cycle_count = 0;
	int  tx_gap_pct = 0;
	int  rx_stall_pct = 0;
	bit  hold_req = 1'b0;

	banked_fir_filter #(
		.TAPS      (TAPS),
		.NUM_BANKS (NUM_BANKS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// shift one sample in and form the truncated, clipped bank sum
	function automatic logic signed [bfir_pkg::SAMPLE_W-1:0] filter_sample(
		input logic signed [bfir_pkg::SAMPLE_W-1:0] sample);
		longint acc;
		longint q;
		int     b;
		for (int i = TAPS - 1; i > 0; i--)
			sample_hist[i] = sample_hist[i-1];
		sample_hist[0] = sample;
		b = (bank_sel >= NUM_BANKS) ? NUM_BANKS - 1 : int'(bank_sel);
		acc = 0;
		for (int i = 0; i < TAPS; i++)
			acc += longint'(coeff_bank[b][i]) * longint'(sample_hist[i]);
		// integer division truncates toward zero
		q = acc / (longint'(1) << bfir_pkg::FRAC_BITS);
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[bfir_pkg::SAMPLE_W-1:0];
	endfunction

	// update the filter state for one accepted transaction
	task automatic apply_item(input fir_item_t it, output bit has_out,
		output logic signed [bfir_pkg::SAMPLE_W-1:0] y);
		has_out = 1'b0;
		y = '0;
		if (it.func == bfir_pkg::FUNC_FILTER) begin
			y = filter_sample(it.audio);
			has_out = 1'b1;
		end else if (it.bank < NUM_BANKS && it.tap < TAPS) begin
			coeff_bank[it.bank][it.tap] = it.coeff;
		end
	endtask

	function automatic logic signed [15:0] rand_word();
		logic signed [15:0] w;
		case ($urandom_range(0, 9))
			0: w = 16'sh7fff;
			1: w = 16'sh8000;
			default: begin
				w = 16'($urandom);
				w = w >>> $urandom_range(0, 8);
			end
		endcase
		return w;
	endfunction

	function automatic fir_item_t random_item();
		fir_item_t it;
		it.func  = ($urandom_range(0, 99) < 60) ? bfir_pkg::FUNC_FILTER : bfir_pkg::FUNC_LOAD;
		it.bank  = bfir_pkg::BANK_W'($urandom_range(0, 3));
		it.tap   = bfir_pkg::TAPIDX_W'($urandom_range(0, TAPS - 1));
		it.coeff = (it.func == bfir_pkg::FUNC_LOAD) ? rand_word() : 16'($urandom);
		it.audio = (it.func == bfir_pkg::FUNC_FILTER) ? rand_word() : 16'($urandom);
		return it;
	endfunction

	// offer one transaction, wait for the handshake, record the expectation
	task automatic offer_item(input fir_item_t it, input bit has_typed,
		input logic signed [bfir_pkg::SAMPLE_W-1:0] typed_out);
		bit                                   has_out;
		logic signed [bfir_pkg::SAMPLE_W-1:0] y;
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.func        <= it.func;
		item_ch.bank_index  <= it.bank;
		item_ch.tap_index   <= it.tap;
		item_ch.coeff_value <= it.coeff;
		item_ch.audio_in    <= it.audio;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		apply_item(it, has_out, y);
		if (has_out)
			expected_audio.push_back(has_typed ? typed_out : y);
	endtask

	task automatic add_row(input logic [bfir_pkg::FUNC_W-1:0] func, input int bank,
		input int tap, input logic signed [15:0] coeff, input logic signed [15:0] audio,
		input bit has_typed, input logic signed [15:0] typed_out);
		table_row_t r;
		r.it.func   = func;
		r.it.bank   = bfir_pkg::BANK_W'(bank);
		r.it.tap    = bfir_pkg::TAPIDX_W'(tap);
		r.it.coeff  = coeff;
		r.it.audio  = audio;
		r.has_typed = has_typed;
		r.typed_out = typed_out;
		stim_table.push_back(r);
	endtask

	task automatic set_idle(input idle_mode_t m);
		case (m)
			IDLE_NONE: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
			IDLE_TX:   begin tx_gap_pct = 77; rx_stall_pct = 0;  end
			IDLE_RX:   begin tx_gap_pct = 0;  rx_stall_pct = 77; end
			default:   begin tx_gap_pct = 6;  rx_stall_pct = 6;  end
		endcase
	endtask

	// drain all results, then allow for a trailing load still in flight
	task automatic wait_idle();
		while (expected_audio.size() != 0)
			@(posedge clk);
		repeat (TAPS + 8) @(posedge clk);
	endtask

	task automatic write_select(input logic [bfir_pkg::SEL_W-1:0] sel);
		cfg_we    <= 1'b1;
		cfg_wdata <= sel;
		@(posedge clk);
		bank_sel = sel;
		cfg_we <= 1'b0;
	endtask

	// result side: check each transaction, drive ready
	initial begin
		int                                   hold_left;
		logic signed [bfir_pkg::SAMPLE_W-1:0] want;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				if (expected_audio.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d", res_ch.audio_out));
				end else begin
					want = expected_audio.pop_front();
					if (res_ch.audio_out !== want)
						report_mismatch($sformatf("audio_out %0d, want %0d",
							res_ch.audio_out, want));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// stimulus
	initial begin
		logic [bfir_pkg::SEL_W-1:0] sel_seq [NUM_PHASES];
		idle_mode_t                 mode_seq [NUM_PHASES];
		fir_item_t                  it;

		sel_seq  = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0};
		mode_seq = '{IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH,
			IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH};

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		item_ch.valid       <= 1'b0;
		item_ch.func        <= bfir_pkg::FUNC_LOAD;
		item_ch.bank_index  <= '0;
		item_ch.tap_index   <= '0;
		item_ch.coeff_value <= '0;
		item_ch.audio_in    <= '0;
		for (int i = 0; i < TAPS; i++)
			sample_hist[i] = '0;
		bank_sel = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(IDLE_NONE);

		// fill every bank; bank 0 starts all zero for the directed table
		for (int b = 0; b < NUM_BANKS; b++) begin
			for (int t = 0; t < TAPS; t++) begin
				it.func  = bfir_pkg::FUNC_LOAD;
				it.bank  = bfir_pkg::BANK_W'(b);
				it.tap   = bfir_pkg::TAPIDX_W'(t);
				it.coeff = (b == 0) ? 16'sh0000 : rand_word();
				it.audio = 16'($urandom);
				offer_item(it, 1'b0, '0);
			end
		end

		// directed table, bank 0 selected
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh1234, 1'b1, 16'sh0000);
		add_row(bfir_pkg::FUNC_LOAD,   0, 0, 16'sh8000, 16'sh0000, 1'b0, '0);
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh7fff, 1'b1, -16'sd32767);
		// -1.0 times -32768 overflows upward
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh8000, 1'b1, 16'sh7fff);
		add_row(bfir_pkg::FUNC_LOAD,   0, 1, 16'sh7fff, 16'sh0000, 1'b0, '0);
		add_row(bfir_pkg::FUNC_LOAD,   0, 0, 16'sh7fff, 16'sh0000, 1'b0, '0);
		// two full negative products clip low
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh8000, 1'b1, 16'sh8000);
		// sum of -32767 truncates to zero, not -1
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh7fff, 1'b1, 16'sh0000);
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh0001, 1'b1, 16'sh7fff);
		// nonexistent bank: load is dropped
		add_row(bfir_pkg::FUNC_LOAD,   3, 0, 16'sh7fff, 16'sh0000, 1'b0, '0);
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh0000, 1'b1, 16'sh0000);
		add_row(bfir_pkg::FUNC_LOAD,   0, 31, 16'shffff, 16'sh0000, 1'b0, '0);
		add_row(bfir_pkg::FUNC_LOAD,   1, 31, 16'sh8000, 16'sh0000, 1'b0, '0);
		// load fields are don't-care on a sample
		add_row(bfir_pkg::FUNC_FILTER, 3, 31, 16'sh7fff, 16'sh8000, 1'b0, '0);
		// sample field is don't-care on a load
		add_row(bfir_pkg::FUNC_LOAD,   2, 0, 16'sh0000, 16'shffff, 1'b0, '0);
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh5555, 1'b0, '0);
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'shaaaa, 1'b0, '0);
		add_row(bfir_pkg::FUNC_LOAD,   0, 16, 16'sh4000, 16'sh0000, 1'b0, '0);
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh7fff, 1'b0, '0);
		add_row(bfir_pkg::FUNC_FILTER, 0, 0, 16'sh0000, 16'sh8000, 1'b0, '0);
		foreach (stim_table[i])
			offer_item(stim_table[i].it, stim_table[i].has_typed, stim_table[i].typed_out);
		item_ch.valid <= 1'b0;

		// random phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_select(sel_seq[p]);
			set_idle(mode_seq[p]);
			// long result hold-off while items keep coming
			if (p == 4)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_item(random_item(), 1'b0, '0);
			item_ch.valid <= 1'b0;
		end

		set_idle(IDLE_NONE);
		wait_idle();
		if (expected_audio.size() != 0)
			report_mismatch($sformatf("%0d results never came", expected_audio.size()));
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[banked_fir_filter.f]
rtl/core/bfir_pkg.sv
rtl/core/bfir_if.sv
rtl/core/bfir_ram.sv
rtl/core/bfir_ctrl.sv
rtl/core/bfir_datapath.sv
rtl/core/banked_fir_filter.sv
sim/banked_fir_filter_test.sv
